FILE: src/vdbr_pkg.sv
// Shared types, constants and mode tables for the video display byte renderer.
// No dependencies; every other file imports this package.
package vdbr_pkg;

    localparam int MODE_W  = 6;
    localparam int ADDR_W  = 13;
    localparam int DATA_W  = 8;
    localparam int COL_W   = 4;
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int GLYPH_W = 8;
    localparam int CCOL_W  = 5;
    localparam int CROW_W  = 4;
    localparam int ART_W   = 2;
    localparam int PIX_W   = 3;

    // Mode bit positions.
    localparam int MB_CSS   = 3;
    localparam int MB_EXT   = 4;
    localparam int MB_GRAPH = 5;

    localparam logic [2:0] GM_SEVEN = 3'd7;

    localparam logic [ADDR_W-1:0] MODE7_LIMIT = 13'd6144;
    localparam logic [ADDR_W-1:0] TEXT_LIMIT  = 13'd512;
    localparam logic [10:0]       SCREEN_H    = 11'd192;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_CELL = 1'b1;

    localparam logic [ART_W-1:0] ART_OFF     = 2'd0;
    localparam logic [ART_W-1:0] ART_PHASE_A = 2'd1;
    localparam logic [ART_W-1:0] ART_PHASE_B = 2'd2;

    typedef enum logic [1:0] {
        JOB_SIMPLE = 2'd0,
        JOB_SEVEN  = 2'd1,
        JOB_TEXT   = 2'd2
    } t_job_kind;

    // Geometry of graphic modes 0..6.
    typedef struct packed {
        logic [ADDR_W-1:0] limit;  // first address out of range
        logic              wide;   // 32 bytes per row (8-pixel span) when set
        logic              bpp1;   // one bit per pixel when set
        logic              pw4;    // pixel width 4 when set, else 2
        logic [1:0]        h;      // pixel height in rows
    } t_gm_info;

    typedef struct packed {
        t_job_kind          kind;
        logic               css;
        logic               addr_zero;
        logic               bpp1;
        logic               wide;
        logic               pw4;
        logic [7:0]         x_base;
        logic [Y_W-1:0]     y;
        logic [Y_W-1:0]     bottom;
        logic [DATA_W-1:0]  data;
        logic [COL_W-1:0]   fg;
        logic [COL_W-1:0]   bg;
        logic [GLYPH_W-1:0] glyph;
        logic [CCOL_W-1:0]  ccol;
        logic [CROW_W-1:0]  crow;
    } t_job;

    typedef struct packed {
        logic               command_kind;
        logic [COL_W-1:0]   fill_colour;
        logic [X_W-1:0]     left_x;
        logic [X_W-1:0]     right_x;
        logic [Y_W-1:0]     top_y;
        logic [Y_W-1:0]     bottom_y;
        logic [GLYPH_W-1:0] glyph_code;
        logic [COL_W-1:0]   back_colour;
        logic [CCOL_W-1:0]  cell_column;
        logic [CROW_W-1:0]  cell_row;
        logic               last_of_run;
    } t_cmd;

    function automatic t_gm_info gm_info(input logic [2:0] gm);
        t_gm_info r;
        case (gm)
            3'd0:    r = '{limit: 13'd1024, wide: 1'b0, bpp1: 1'b0, pw4: 1'b1, h: 2'd3};
            3'd1:    r = '{limit: 13'd1024, wide: 1'b0, bpp1: 1'b1, pw4: 1'b0, h: 2'd3};
            3'd2:    r = '{limit: 13'd2048, wide: 1'b1, bpp1: 1'b0, pw4: 1'b0, h: 2'd3};
            3'd3:    r = '{limit: 13'd1536, wide: 1'b0, bpp1: 1'b1, pw4: 1'b0, h: 2'd2};
            3'd4:    r = '{limit: 13'd3072, wide: 1'b1, bpp1: 1'b0, pw4: 1'b0, h: 2'd2};
            3'd5:    r = '{limit: 13'd3072, wide: 1'b0, bpp1: 1'b1, pw4: 1'b0, h: 2'd1};
            3'd6:    r = '{limit: 13'd6144, wide: 1'b1, bpp1: 1'b0, pw4: 1'b0, h: 2'd1};
            default: r = '{limit: 13'd0,    wide: 1'b1, bpp1: 1'b1, pw4: 1'b0, h: 2'd1};
        endcase
        return r;
    endfunction

endpackage

FILE: src/vdbr_ifs.sv
// Handshake channel interfaces: video-memory write input, draw command output,
// and the configuration write channel. Depends on vdbr_pkg.
interface vdbr_item_if import vdbr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode_bits;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, mode_bits, address, data_byte, input ready);
    modport sink   (input valid, mode_bits, address, data_byte, output ready);
endinterface

interface vdbr_cmd_if import vdbr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command_kind;
    logic [COL_W-1:0]   fill_colour;
    logic [X_W-1:0]     left_x;
    logic [X_W-1:0]     right_x;
    logic [Y_W-1:0]     top_y;
    logic [Y_W-1:0]     bottom_y;
    logic [GLYPH_W-1:0] glyph_code;
    logic [COL_W-1:0]   back_colour;
    logic [CCOL_W-1:0]  cell_column;
    logic [CROW_W-1:0]  cell_row;
    logic               last_of_run;

    modport source (output valid, command_kind, fill_colour, left_x, right_x, top_y,
                    bottom_y, glyph_code, back_colour, cell_column, cell_row,
                    last_of_run, input ready);
    modport sink   (input valid, command_kind, fill_colour, left_x, right_x, top_y,
                    bottom_y, glyph_code, back_colour, cell_column, cell_row,
                    last_of_run, output ready);
endinterface

interface vdbr_cfg_if import vdbr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ART_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: src/vdbr_front.sv
// Front end: accepts video-memory writes, range-checks them and turns each
// into a job descriptor for the queue. Depends on vdbr_pkg and vdbr_ifs.
module vdbr_front import vdbr_pkg::*; (
    vdbr_item_if.sink i_item,
    input  logic      i_full,
    output logic      o_push,
    output t_job      o_push_job
);

    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              css;
    logic [2:0]        gm;
    t_gm_info          info;
    logic [8:0]        row_idx;
    logic [10:0]       y_full;
    logic [COL_W-1:0]  bgv;
    logic              keep;
    t_job              job;

    always_comb begin
        mode    = i_item.mode_bits;
        a       = i_item.address;
        b       = i_item.data_byte;
        css     = mode[MB_CSS];
        gm      = mode[2:0];
        info    = gm_info(gm);
        row_idx = info.wide ? {1'b0, a[12:5]} : a[12:4];
        y_full  = 11'(row_idx) * 11'(info.h);
        bgv     = css ? 4'd8 : 4'd1;
        keep    = 1'b0;
        job     = '0;
        job.css  = css;
        job.data = b;

        if (mode[MB_GRAPH]) begin
            if (gm == GM_SEVEN) begin
                job.kind      = JOB_SEVEN;
                job.x_base    = {a[4:0], 3'b000};
                job.y         = a[12:5];
                job.bottom    = a[12:5] + 8'd1;
                job.addr_zero = (a == '0);
                keep          = (a < MODE7_LIMIT);
            end else begin
                job.kind   = JOB_SIMPLE;
                job.bpp1   = info.bpp1;
                job.wide   = info.wide;
                job.pw4    = info.pw4;
                job.x_base = info.wide ? {a[4:0], 3'b000} : {a[3:0], 4'b0000};
                job.y      = y_full[7:0];
                job.bottom = y_full[7:0] + {6'b0, info.h};
                keep       = (a < info.limit) && (y_full < SCREEN_H);
            end
        end else begin
            job.kind = JOB_TEXT;
            job.ccol = a[4:0];
            job.crow = a[8:5];
            keep     = (a < TEXT_LIMIT);
            if (b inside {[8'd0:8'd31]}) begin
                job.glyph = b + 8'd32;
                job.fg    = bgv;
            end else if (b inside {[8'd32:8'd63]}) begin
                job.glyph = b - 8'd32;
                job.fg    = bgv;
            end else if (b inside {[8'd64:8'd95]}) begin
                job.glyph = b - 8'd32;
                job.bg    = bgv;
            end else if (b inside {[8'd96:8'd127]}) begin
                job.glyph = b - 8'd96;
                job.bg    = bgv;
            end else if (mode[MB_EXT]) begin
                // Semigraphics 6: two color bits from the byte, one from the color set.
                job.fg    = {1'b0, css, b[7:6]} + 4'd1;
                job.glyph = (b & 8'hBF) + 8'd32;
            end else begin
                // Semigraphics 4.
                job.fg    = {1'b0, b[6:4]} + 4'd1;
                job.glyph = {4'b0, b[3:0]} + 8'd96;
            end
        end
    end

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full && keep;
    assign o_push_job   = job;

endmodule

FILE: src/vdbr_queue.sv
// Four-entry job queue between the front end and the command sequencer.
// Depends on vdbr_pkg.
module vdbr_queue import vdbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head_job
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    assign o_full       = (r_count == (PTR_W+1)'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_mem[r_rd_ptr];

endmodule

FILE: src/vdbr_back.sv
// Command sequencer: walks the pixels of the head job, keeps the artifact color
// history and the configuration register, and drives the output register.
// Depends on vdbr_pkg and vdbr_ifs.
module vdbr_back import vdbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vdbr_cfg_if.sink    i_cfg,
    input  logic        i_head_valid,
    input  t_job        i_head_job,
    output logic        o_pop,
    vdbr_cmd_if.source  o_cmd
);

    logic [ART_W-1:0] r_art_mode;
    logic [COL_W-1:0] r_hist1, r_hist2, r_hist3;
    logic [COL_W-1:0] n_hist1, n_hist2, n_hist3;
    logic [PIX_W-1:0] r_pix, n_pix;
    logic [1:0]       r_art_cnt, n_art_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             r_out, n_out;

    logic             step;
    logic             pop;
    logic             advance;
    logic [7:0]       xi;
    logic [X_W-1:0]   x_end;
    logic [3:0]       pix1;
    logic [X_W-1:0]   off;
    logic [X_W-1:0]   left;
    logic [DATA_W-1:0] shifted;
    logic [COL_W-1:0] c;
    logic             art_en;
    logic             lit;
    logic             fire;
    logic             clr;
    logic [COL_W-1:0] e1, e2, e3;
    logic [COL_W-1:0] ca;
    t_cmd             cmd;

    assign step = i_head_valid && (!r_out_valid || o_cmd.ready);

    always_comb begin
        n_hist1   = r_hist1;
        n_hist2   = r_hist2;
        n_hist3   = r_hist3;
        n_pix     = r_pix;
        n_art_cnt = r_art_cnt;
        pop       = 1'b0;
        advance   = 1'b0;
        cmd       = '0;
        xi        = i_head_job.x_base + {5'b0, r_pix};
        x_end     = {1'b0, i_head_job.x_base} + (i_head_job.wide ? 9'd8 : 9'd16);
        pix1      = {1'b0, r_pix} + 4'd1;
        off       = i_head_job.pw4 ? {3'b0, pix1, 2'b00} : {4'b0, pix1, 1'b0};
        left      = x_end - off;
        shifted   = i_head_job.data >> {r_pix[1:0], 1'b0};
        art_en    = (r_art_mode != ART_OFF) && i_head_job.css;
        lit       = i_head_job.data[3'd7 - r_pix];
        clr       = (r_pix == '0) && i_head_job.addr_zero;
        e1        = clr ? '0 : r_hist1;
        e2        = clr ? '0 : r_hist2;
        e3        = clr ? '0 : r_hist3;
        fire      = 1'b0;
        c         = '0;

        case (r_art_mode)
            ART_PHASE_A: ca = r_pix[0] ? 4'd3 : 4'd4;
            ART_PHASE_B: ca = r_pix[0] ? 4'd4 : 4'd3;
            default:     ca = 4'd1;
        endcase

        case (i_head_job.kind)
            JOB_TEXT: begin
                cmd.command_kind = KIND_CELL;
                cmd.fill_colour  = i_head_job.fg;
                cmd.glyph_code   = i_head_job.glyph;
                cmd.back_colour  = i_head_job.bg;
                cmd.cell_column  = i_head_job.ccol;
                cmd.cell_row     = i_head_job.crow;
                cmd.last_of_run  = 1'b1;
                pop              = 1'b1;
                n_hist1          = i_head_job.fg;
                n_hist2          = i_head_job.bg;
            end
            JOB_SIMPLE: begin
                if (i_head_job.bpp1) begin
                    c = i_head_job.data[r_pix] ? (i_head_job.css ? 4'd5 : 4'd1) : 4'd0;
                end else begin
                    c = {2'b0, shifted[1:0]} + 4'd1 + (i_head_job.css ? 4'd4 : 4'd0);
                end
                cmd.command_kind = KIND_FILL;
                cmd.fill_colour  = c;
                cmd.left_x       = left;
                cmd.right_x      = left + (i_head_job.pw4 ? 9'd4 : 9'd2);
                cmd.top_y        = i_head_job.y;
                cmd.bottom_y     = i_head_job.bottom;
                cmd.last_of_run  = (r_pix == (i_head_job.bpp1 ? 3'd7 : 3'd3));
                if (cmd.last_of_run) begin
                    pop   = 1'b1;
                    n_pix = '0;
                end else begin
                    n_pix = r_pix + 1'b1;
                end
            end
            JOB_SEVEN: begin
                cmd.command_kind = KIND_FILL;
                cmd.top_y        = i_head_job.y;
                cmd.bottom_y     = i_head_job.bottom;
                if (r_art_cnt == 2'd0) begin
                    c = lit ? (art_en ? 4'd5 : 4'd1) : 4'd0;
                    cmd.fill_colour = c;
                    cmd.left_x      = {1'b0, xi};
                    cmd.right_x     = {1'b0, xi} + 9'd1;
                    fire = art_en && (xi >= 8'd3) && lit && (e1 == '0) && (e2 != '0)
                           && (e3 == '0);
                    if (art_en) begin
                        n_hist3 = e2;
                        n_hist2 = e1;
                        n_hist1 = c;
                    end else begin
                        n_hist3 = e3;
                        n_hist2 = e2;
                        n_hist1 = e1;
                    end
                    if (fire) begin
                        n_art_cnt = 2'd1;
                    end else begin
                        advance = 1'b1;
                    end
                end else begin
                    cmd.fill_colour = ca;
                    cmd.left_x      = {1'b0, xi} - 9'd3 + {7'b0, r_art_cnt};
                    cmd.right_x     = {1'b0, xi} - 9'd2 + {7'b0, r_art_cnt};
                    if (r_art_cnt == 2'd3) begin
                        n_art_cnt = 2'd0;
                        advance   = 1'b1;
                    end else begin
                        n_art_cnt = r_art_cnt + 2'd1;
                    end
                end
                if (advance) begin
                    cmd.last_of_run = (r_pix == 3'd7);
                    if (r_pix == 3'd7) begin
                        pop   = 1'b1;
                        n_pix = '0;
                    end else begin
                        n_pix = r_pix + 1'b1;
                    end
                end
            end
            default: begin
                pop = 1'b1;
            end
        endcase

        n_out       = cmd;
        n_out_valid = step ? 1'b1 : (o_cmd.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_art_mode  <= ART_OFF;
            r_hist1     <= '0;
            r_hist2     <= '0;
            r_hist3     <= '0;
            r_pix       <= '0;
            r_art_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_art_mode <= i_cfg.data;
            end
            r_out_valid <= n_out_valid;
            if (step) begin
                r_hist1   <= n_hist1;
                r_hist2   <= n_hist2;
                r_hist3   <= n_hist3;
                r_pix     <= n_pix;
                r_art_cnt <= n_art_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_pop       = step && pop;
    assign i_cfg.ready = 1'b1;

    assign o_cmd.valid        = r_out_valid;
    assign o_cmd.command_kind = r_out.command_kind;
    assign o_cmd.fill_colour  = r_out.fill_colour;
    assign o_cmd.left_x       = r_out.left_x;
    assign o_cmd.right_x      = r_out.right_x;
    assign o_cmd.top_y        = r_out.top_y;
    assign o_cmd.bottom_y     = r_out.bottom_y;
    assign o_cmd.glyph_code   = r_out.glyph_code;
    assign o_cmd.back_colour  = r_out.back_colour;
    assign o_cmd.cell_column  = r_out.cell_column;
    assign o_cmd.cell_row     = r_out.cell_row;
    assign o_cmd.last_of_run  = r_out.last_of_run;

endmodule

FILE: src/video_display_byte_renderer.sv
// Top level of the video display byte renderer: front end, job queue and
// command sequencer. Depends on vdbr_pkg, vdbr_ifs and the three submodules.
//
//  Channel   Direction  Carries
//  i_item    in         mode_bits, address, data_byte (one video-memory write)
//  o_cmd     out        one draw command (fill rectangle or character cell)
//  i_cfg     in         artifact_mode write data (always ready)
//
// The sequencer emits one command per clock unless o_cmd stalls; a write causes
// 1 command for a text cell, 4 or 8 for graphic modes 0..6, and 8 to 20 for
// mode 7 with artifacting. Out-of-range writes are dropped in the front end and
// never reach the sequencer. The four-entry queue lets writes be accepted
// while earlier ones are still drawing; i_item.ready falls only when it is full.
// Reset is synchronous and active low; it clears the queue, the color history
// and the artifact register. A stalled o_cmd holds the sequencer in place.
module video_display_byte_renderer import vdbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vdbr_item_if.sink   i_item,
    vdbr_cfg_if.sink    i_cfg,
    vdbr_cmd_if.source  o_cmd
);

    logic push;
    t_job push_job;
    logic full;
    logic head_valid;
    t_job head_job;
    logic pop;

    // Classification and range checks happen combinationally at acceptance.
    vdbr_front u_front (
        .i_item     (i_item),
        .i_full     (full),
        .o_push     (push),
        .o_push_job (push_job)
    );

    // The queue decouples acceptance from command emission.
    vdbr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_job   (push_job),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head_job   (head_job)
    );

    // The sequencer pops a job in the same cycle that its final command is registered.
    vdbr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_head_valid (head_valid),
        .i_head_job   (head_job),
        .o_pop        (pop),
        .o_cmd        (o_cmd)
    );

endmodule
